// ===== rtl/pdvm_pkg.sv =====
// Shared types, register indexes and reset values for the perspective divide
// and viewport map block. No dependencies.
package pdvm_pkg;

   localparam int FRAC_BITS_DEF = 16;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X  = 3'd0,
      CSR_ORIGIN_Y  = 3'd1,
      CSR_WIDTH     = 3'd2,
      CSR_HEIGHT    = 3'd3,
      CSR_W_TOL     = 3'd4
   } pdvm_csr_type;

   localparam logic [15:0] ORIGIN_X_RST = 16'd0;
   localparam logic [15:0] ORIGIN_Y_RST = 16'd0;
   localparam logic [15:0] WIDTH_RST    = 16'd640;
   localparam logic [15:0] HEIGHT_RST   = 16'd480;
   localparam logic [15:0] W_TOL_RST    = 16'd1;

   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_MAX = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] tex_u;
      logic [31:0] tex_v;
      logic        persp;
      logic        last;
      logic        z_zero;
      logic        z_neg;
      logic        w_zero;
      logic        w_neg;
      logic        x_zero;
      logic        x_neg;
      logic        y_zero;
      logic        y_neg;
   } pdvm_carry_type;

   typedef struct packed {
      logic [15:0] screen_x;
      logic [15:0] screen_y;
      logic [31:0] ndc_x;
      logic [31:0] ndc_y;
      logic [31:0] recip_z;
      logic [31:0] tex_u;
      logic [31:0] tex_v;
      logic        range_error;
      logic        last;
   } pdvm_rsp_type;

endpackage

// ===== rtl/perspective_divide_viewport_map.sv =====
// Perspective divide and viewport map: three restoring dividers, texture scale, pixel map.
// Depends on pdvm_pkg.
// Throughput: one word per cycle while the skid word is empty; the dividers retire one
// quotient bit per stage over FRAC_BITS + 32 stages. Output register plus skid word
// decouple the two channels.
// Reset: synchronous; empties the pipeline and loads the viewport registers' reset values.
module perspective_divide_viewport_map
   import pdvm_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_clip_x,
   input  logic [31:0] req_clip_y,
   input  logic [31:0] req_clip_z,
   input  logic [31:0] req_clip_w,
   input  logic [31:0] req_tex_u_in,
   input  logic [31:0] req_tex_v_in,
   input  logic        req_tex_used,
   input  logic        req_last_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_screen_x,
   output logic [15:0] rsp_screen_y,
   output logic [31:0] rsp_ndc_x,
   output logic [31:0] rsp_ndc_y,
   output logic [31:0] rsp_recip_z,
   output logic [31:0] rsp_tex_u_out,
   output logic [31:0] rsp_tex_v_out,
   output logic        rsp_range_error,
   output logic        rsp_last_out
);

   localparam int NW = 32 + FRAC_BITS;
   localparam int AW = NW + 33;
   localparam int TW = 52;
   localparam logic [32:0] ONE33 = 33'(1) << FRAC_BITS;

   function automatic logic [31:0] mag32(input logic [31:0] a);
      mag32 = a[31] ? 32'(-a) : a;
   endfunction

   function automatic logic [AW-1:0] div_step(input logic [AW-1:0] a, input logic [31:0] d);
      logic [AW-1:0] s;
      logic [33:0]   t;
      s = a << 1;
      t = {1'b0, s[AW-1:NW]} - {2'b0, d};
      if (!t[33]) begin
         s = {t[32:0], s[NW-1:1], 1'b1};
      end
      div_step = s;
   endfunction

   function automatic logic [32:0] fix_q(input logic [NW-1:0] q, input logic neg);
      logic big;
      big = (q[NW-1:31] != '0);
      if (!big) begin
         fix_q = {1'b0, neg ? 32'(-q[31:0]) : q[31:0]};
      end else if (neg && q[NW-1:32] == '0 && q[31:0] == NEG_MAX) begin
         fix_q = {1'b0, NEG_MAX};
      end else begin
         fix_q = {1'b1, neg ? NEG_MAX : POS_MAX};
      end
   endfunction

   function automatic logic [32:0] zero_div(input logic zero, input logic neg);
      zero_div = {1'b1, zero ? 32'd0 : (neg ? NEG_MAX : POS_MAX)};
   endfunction

   function automatic logic [32:0] sat64(input logic signed [63:0] v);
      if (v[63:31] == '0 || v[63:31] == '1) begin
         sat64 = {1'b0, v[31:0]};
      end else begin
         sat64 = {1'b1, v[63] ? NEG_MAX : POS_MAX};
      end
   endfunction

   function automatic logic [16:0] pix16(input logic signed [TW-1:0] total);
      logic signed [TW-1:0] adj;
      logic signed [TW-1:0] p;
      adj = total[TW-1] ? total + ((TW'(1) <<< (FRAC_BITS + 1)) - TW'(1)) : total;
      p   = adj >>> (FRAC_BITS + 1);
      if (p[TW-1:15] == '0 || p[TW-1:15] == '1) begin
         pix16 = {1'b0, p[15:0]};
      end else begin
         pix16 = {1'b1, p[TW-1] ? 16'h8000 : 16'h7FFF};
      end
   endfunction

   // viewport registers
   logic [15:0] org_x_ff, org_y_ff, width_ff, height_ff, w_tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff  <= ORIGIN_X_RST;
         org_y_ff  <= ORIGIN_Y_RST;
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         w_tol_ff  <= W_TOL_RST;
      end else if (csr_wr_en) begin
         case (pdvm_csr_type'(csr_index))
            CSR_ORIGIN_X: org_x_ff  <= csr_wdata;
            CSR_ORIGIN_Y: org_y_ff  <= csr_wdata;
            CSR_WIDTH:    width_ff  <= csr_wdata;
            CSR_HEIGHT:   height_ff <= csr_wdata;
            CSR_W_TOL:    w_tol_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic en;
   logic skid_vld_ff;
   assign en        = !skid_vld_ff;
   assign req_ready = en;

   // input prep
   logic signed [32:0] dw_s;
   logic [32:0]        dw_a;
   pdvm_carry_type     car_in;

   always_comb begin
      dw_s = $signed({req_clip_w[31], req_clip_w}) - $signed(ONE33);
      dw_a = dw_s[32] ? 33'(-dw_s) : 33'(dw_s);
      car_in.tex_u  = req_tex_u_in;
      car_in.tex_v  = req_tex_v_in;
      car_in.persp  = req_tex_used && (dw_a > {17'd0, w_tol_ff});
      car_in.last   = req_last_in;
      car_in.z_zero = (req_clip_z == '0);
      car_in.z_neg  = req_clip_z[31];
      car_in.w_zero = (req_clip_w == '0);
      car_in.w_neg  = req_clip_w[31];
      car_in.x_zero = (req_clip_x == '0);
      car_in.x_neg  = req_clip_x[31];
      car_in.y_zero = (req_clip_y == '0);
      car_in.y_neg  = req_clip_y[31];
   end

   // divider stages
   logic           vld_ff   [0:NW];
   logic [AW-1:0]  acc_z_ff [0:NW];
   logic [AW-1:0]  acc_x_ff [0:NW];
   logic [AW-1:0]  acc_y_ff [0:NW];
   logic [31:0]    dz_ff    [0:NW];
   logic [31:0]    dw_ff    [0:NW];
   pdvm_carry_type car_ff   [0:NW];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NW; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int k = 0; k < NW; k++) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_z_ff[0] <= {33'd0, NW'(1) << (2 * FRAC_BITS)};
         acc_x_ff[0] <= {33'd0, NW'(mag32(req_clip_x)) << FRAC_BITS};
         acc_y_ff[0] <= {33'd0, NW'(mag32(req_clip_y)) << FRAC_BITS};
         dz_ff[0]    <= mag32(req_clip_z);
         dw_ff[0]    <= mag32(req_clip_w);
         car_ff[0]   <= car_in;
         for (int k = 0; k < NW; k++) begin
            acc_z_ff[k+1] <= div_step(acc_z_ff[k], dz_ff[k]);
            acc_x_ff[k+1] <= div_step(acc_x_ff[k], dw_ff[k]);
            acc_y_ff[k+1] <= div_step(acc_y_ff[k], dw_ff[k]);
            dz_ff[k+1]    <= dz_ff[k];
            dw_ff[k+1]    <= dw_ff[k];
            car_ff[k+1]   <= car_ff[k];
         end
      end
   end

   // resolve quotients
   pdvm_carry_type car_nw;
   logic [32:0]    rz_in, nx_in, ny_in;

   always_comb begin
      car_nw = car_ff[NW];
      rz_in  = car_nw.z_zero ? {1'b1, POS_MAX}
                             : fix_q(acc_z_ff[NW][NW-1:0], car_nw.z_neg);
      nx_in  = car_nw.w_zero ? zero_div(car_nw.x_zero, car_nw.x_neg)
                             : fix_q(acc_x_ff[NW][NW-1:0], car_nw.x_neg ^ car_nw.w_neg);
      ny_in  = car_nw.w_zero ? zero_div(car_nw.y_zero, car_nw.y_neg)
                             : fix_q(acc_y_ff[NW][NW-1:0], car_nw.y_neg ^ car_nw.w_neg);
   end

   logic           m_vld_ff;
   logic [31:0]    m_rz_ff, m_nx_ff, m_ny_ff;
   logic           m_err_ff;
   pdvm_carry_type m_car_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (en) begin
         m_vld_ff <= vld_ff[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_rz_ff  <= rz_in[31:0];
         m_nx_ff  <= nx_in[31:0];
         m_ny_ff  <= ny_in[31:0];
         m_err_ff <= rz_in[32] | nx_in[32] | ny_in[32];
         m_car_ff <= car_nw;
      end
   end

   // multiply stage
   logic signed [32:0] nx_one, ny_one;
   logic signed [63:0] prod_u_in, prod_v_in;
   logic signed [49:0] prod_x_in, prod_y_in;

   always_comb begin
      nx_one    = $signed({m_nx_ff[31], m_nx_ff}) + $signed(ONE33);
      ny_one    = $signed(ONE33) - $signed({m_ny_ff[31], m_ny_ff});
      prod_u_in = $signed(m_car_ff.tex_u) * $signed(m_rz_ff);
      prod_v_in = $signed(m_car_ff.tex_v) * $signed(m_rz_ff);
      prod_x_in = nx_one * $signed({1'b0, width_ff});
      prod_y_in = ny_one * $signed({1'b0, height_ff});
   end

   logic               p_vld_ff;
   logic signed [63:0] p_u_ff, p_v_ff;
   logic signed [49:0] p_x_ff, p_y_ff;
   logic [31:0]        p_rz_ff, p_nx_ff, p_ny_ff;
   logic               p_err_ff;
   pdvm_carry_type     p_car_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (en) begin
         p_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_u_ff   <= prod_u_in;
         p_v_ff   <= prod_v_in;
         p_x_ff   <= prod_x_in;
         p_y_ff   <= prod_y_in;
         p_rz_ff  <= m_rz_ff;
         p_nx_ff  <= m_nx_ff;
         p_ny_ff  <= m_ny_ff;
         p_err_ff <= m_err_ff;
         p_car_ff <= m_car_ff;
      end
   end

   // final stage: texture floor shift, pixel rounding, saturation
   logic [32:0]          tu_s, tv_s;
   logic signed [TW-1:0] tot_x, tot_y;
   logic [16:0]          px_s, py_s;
   pdvm_rsp_type         t_in;

   always_comb begin
      tu_s  = sat64(p_u_ff >>> FRAC_BITS);
      tv_s  = sat64(p_v_ff >>> FRAC_BITS);
      tot_x = (TW'($signed(org_x_ff)) <<< (FRAC_BITS + 1)) + TW'(p_x_ff)
              + (TW'(1) <<< FRAC_BITS);
      tot_y = (TW'($signed(org_y_ff)) <<< (FRAC_BITS + 1)) + TW'(p_y_ff)
              + (TW'(1) <<< FRAC_BITS);
      px_s  = pix16(tot_x);
      py_s  = pix16(tot_y);
      t_in.screen_x    = px_s[15:0];
      t_in.screen_y    = py_s[15:0];
      t_in.ndc_x       = p_nx_ff;
      t_in.ndc_y       = p_ny_ff;
      t_in.recip_z     = p_rz_ff;
      t_in.tex_u       = p_car_ff.persp ? tu_s[31:0] : p_car_ff.tex_u;
      t_in.tex_v       = p_car_ff.persp ? tv_s[31:0] : p_car_ff.tex_v;
      t_in.range_error = p_err_ff | px_s[16] | py_s[16]
                         | (p_car_ff.persp & (tu_s[32] | tv_s[32]));
      t_in.last        = p_car_ff.last;
   end

   logic         t_vld_ff;
   pdvm_rsp_type t_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_vld_ff <= 1'b0;
      end else if (en) begin
         t_vld_ff <= p_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_data_ff <= t_in;
      end
   end

   // output register and skid word
   logic         rsp_valid_ff;
   logic         out_free;
   pdvm_rsp_type out_ff, skid_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_vld_ff  <= 1'b0;
      end else if (skid_vld_ff) begin
         if (out_free) begin
            rsp_valid_ff <= 1'b1;
            skid_vld_ff  <= 1'b0;
         end
      end else if (t_vld_ff) begin
         if (out_free) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_vld_ff <= 1'b1;
         end
      end else if (out_free) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (out_free) begin
            out_ff <= skid_ff;
         end
      end else if (t_vld_ff) begin
         if (out_free) begin
            out_ff <= t_data_ff;
         end else begin
            skid_ff <= t_data_ff;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_screen_x    = out_ff.screen_x;
   assign rsp_screen_y    = out_ff.screen_y;
   assign rsp_ndc_x       = out_ff.ndc_x;
   assign rsp_ndc_y       = out_ff.ndc_y;
   assign rsp_recip_z     = out_ff.recip_z;
   assign rsp_tex_u_out   = out_ff.tex_u;
   assign rsp_tex_v_out   = out_ff.tex_v;
   assign rsp_range_error = out_ff.range_error;
   assign rsp_last_out    = out_ff.last;

endmodule

// ===== rtl/pdvm_checker.sv =====
// Port-level checks for perspective_divide_viewport_map, bound to the top level.
// Depends on pdvm_pkg and the top level's port names.
module pdvm_checker
   import pdvm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_ndc_x,
   input logic [15:0] rsp_screen_x
);

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result word present right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ndc_x) && $stable(rsp_screen_x))
      else $error("stalled result word changed");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result word waiting");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      !req_ready && rsp_ready |=> req_ready)
      else $error("input stayed stalled after result taken");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("input word withdrawn before accept");

endmodule

bind perspective_divide_viewport_map pdvm_checker u_pdvm_checker (.*);

// ===== tb/sv/perspective_divide_viewport_map_test.sv =====
// Self-checking bench for perspective_divide_viewport_map: directed and random vertices,
// each response checked against an in-bench predictor. Depends on pdvm_pkg and the block.
module perspective_divide_viewport_map_test;
   import pdvm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB = FRAC_BITS_DEF;
   localparam int LATENCY = FB + 36;
   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_clip_x = '0, req_clip_y = '0, req_clip_z = '0, req_clip_w = '0;
   logic [31:0] req_tex_u_in = '0, req_tex_v_in = '0;
   logic        req_tex_used = 1'b0, req_last_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_screen_x, rsp_screen_y;
   logic [31:0] rsp_ndc_x, rsp_ndc_y, rsp_recip_z, rsp_tex_u_out, rsp_tex_v_out;
   logic        rsp_range_error, rsp_last_out;

   perspective_divide_viewport_map dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // viewport registers as the block should hold them
   logic signed [15:0] vp_org_x = ORIGIN_X_RST, vp_org_y = ORIGIN_Y_RST;
   logic [15:0] vp_width = WIDTH_RST, vp_height = HEIGHT_RST, vp_w_tol = W_TOL_RST;

   pdvm_rsp_type pending_pixels[$];
   int errors = 0;
   int idle_pct = 27;
   bit hold_off = 1'b0;
   int quiet_cycles = 0;

   function automatic longint clamp(longint v, longint lo, longint hi, ref bit err);
      if (v < lo) begin
         err = 1'b1;
         return lo;
      end
      if (v > hi) begin
         err = 1'b1;
         return hi;
      end
      return v;
   endfunction

   function automatic longint fix_div(longint num, longint den, ref bit err);
      if (den == 0) begin
         err = 1'b1;
         return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
      end
      return clamp((num <<< FB) / den, -64'sd2147483648, 64'sd2147483647, err);
   endfunction

   function automatic longint map_pixel(longint org, longint twice_frac, ref bit err);
      longint one;
      one = 64'sd1 <<< FB;
      return clamp((org * 2 * one + twice_frac + one) / (2 * one), -32768, 32767, err);
   endfunction

   function automatic longint scale_tex(longint t, longint rz, ref bit err);
      longint p;
      p = t * rz;
      return clamp(p >>> FB, -64'sd2147483648, 64'sd2147483647, err);
   endfunction

   function automatic pdvm_rsp_type project_vertex(logic [31:0] cx, cy, cz, cw, tu, tv,
                                                    logic used, logic lst);
      pdvm_rsp_type r;
      bit err;
      longint one, x, y, z, w, u, v, rz, nx, ny, dw;
      err = 1'b0;
      one = 64'sd1 <<< FB;
      x = longint'(signed'(cx)); y = longint'(signed'(cy));
      z = longint'(signed'(cz)); w = longint'(signed'(cw));
      u = longint'(signed'(tu)); v = longint'(signed'(tv));
      if (z == 0) begin
         err = 1'b1;
         rz = 64'sd2147483647;
      end else begin
         rz = clamp((64'sd1 <<< (2 * FB)) / z, -64'sd2147483648, 64'sd2147483647, err);
      end
      dw = w - one;
      if (dw < 0) dw = -dw;
      if (dw > longint'(vp_w_tol) && used) begin
         u = scale_tex(u, rz, err);
         v = scale_tex(v, rz, err);
      end
      nx = fix_div(x, w, err);
      ny = fix_div(y, w, err);
      r.screen_x = 16'(map_pixel(longint'(vp_org_x), (nx + one) * longint'(vp_width), err));
      r.screen_y = 16'(map_pixel(longint'(vp_org_y), (one - ny) * longint'(vp_height), err));
      r.ndc_x = 32'(nx);
      r.ndc_y = 32'(ny);
      r.recip_z = 32'(rz);
      r.tex_u = 32'(u);
      r.tex_v = 32'(v);
      r.range_error = err;
      r.last = lst;
      return r;
   endfunction

   task automatic send_vertex(logic [31:0] cx, cy, cz, cw, tu, tv, logic used, logic lst);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_clip_x <= cx; req_clip_y <= cy; req_clip_z <= cz; req_clip_w <= cw;
      req_tex_u_in <= tu; req_tex_v_in <= tv;
      req_tex_used <= used; req_last_in <= lst;
      do @(posedge clock); while (!req_ready);
      pending_pixels.push_back(project_vertex(cx, cy, cz, cw, tu, tv, used, lst));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic write_csr(pdvm_csr_type idx, logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      case (idx)
         CSR_ORIGIN_X: vp_org_x = val;
         CSR_ORIGIN_Y: vp_org_y = val;
         CSR_WIDTH:    vp_width = val;
         CSR_HEIGHT:   vp_height = val;
         CSR_W_TOL:    vp_w_tol = val;
         default: ;
      endcase
   endtask

   task automatic set_viewport(logic [15:0] ox, oy, wd, ht, tol);
      drain();
      write_csr(CSR_ORIGIN_X, ox);
      write_csr(CSR_ORIGIN_Y, oy);
      write_csr(CSR_WIDTH, wd);
      write_csr(CSR_HEIGHT, ht);
      write_csr(CSR_W_TOL, tol);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] rand_fix();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(8 << FB)) - (4 << FB));
         2: return 32'($signed($urandom_range(1 << 12)) - (1 << 11));
         3: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                      : 32'h8000_0000 + $urandom_range(3);
         default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
      endcase
   endfunction

   function automatic logic [31:0] rand_w();
      case ($urandom_range(5))
         0: return 32'(1 << FB) + 32'($signed($urandom_range(4)) - 2);
         1: return '0;
         2: return $urandom;
         default: return 32'($signed($urandom_range(6 << FB)) - (3 << FB));
      endcase
   endfunction

   task automatic test_directed();
      logic [31:0] one;
      one = 32'(1 << FB);
      send_vertex(0, 0, one, one, one, one, 1'b1, 1'b0);
      send_vertex(one, one, 2 * one, 2 * one, 3 * one, -3 * one, 1'b1, 1'b1);
      send_vertex(-one, -one, 0, one, 5, 7, 1'b1, 1'b0);
      send_vertex(5 * one, -7 * one, one, 0, 1, 1, 1'b0, 1'b1);
      send_vertex(-5 * one, 0, one, 0, 1, 1, 1'b0, 1'b0);
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF,
                  32'h8000_0000, 1'b1, 1'b1);
      send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
      send_vertex(one, one, 1, -one, one, one, 1'b1, 1'b0);
      send_vertex(one, one, -1, one + 1, -one, one, 1'b1, 1'b0);
      send_vertex(one, one, 3, one + 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_vertex(3 * one, -2 * one, 4 * one, one - 1, 9, 9, 1'b0, 1'b0);
      send_vertex(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 2, 32'hAAAA_5555, 32'h5555_AAAA,
                  1'b1, 1'b0);
   endtask

   task automatic test_random(int count);
      repeat (count)
         send_vertex(rand_fix(), rand_fix(), rand_fix(), rand_w(), rand_fix(), rand_fix(),
                     1'($urandom), 1'($urandom));
   endtask

   task automatic test_no_idle(int count);
      idle_pct = 0;
      test_random(count);
      idle_pct = 27;
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      idle_pct = 0;
      test_random(120);
      idle_pct = 27;
      req_valid <= 1'b0;
      @(negedge clock);
      wait (!hold_off);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(200);
      set_viewport(16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'd0);
      test_directed();
      test_random(200);
      set_viewport(16'h7FFF, 16'h8000, 16'd0, 16'd0, 16'hFFFF);
      test_directed();
      test_random(150);
      set_viewport(16'hFF9C, 16'd37, 16'd1920, 16'd1080, 16'd64);
      test_no_idle(250);
      test_backpressure();
      test_random(150);
      drain();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // hold the result side off long enough to fill the pipe
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off) begin
         rsp_ready <= 1'b0;
         repeat (300) @(negedge clock);
         hold_off = 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      pdvm_rsp_type exp_pix;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected response word");
            errors++;
         end else begin
            exp_pix = pending_pixels.pop_front();
            if (rsp_screen_x !== exp_pix.screen_x) begin
               $error("screen_x exp %h got %h", exp_pix.screen_x, rsp_screen_x); errors++;
            end
            if (rsp_screen_y !== exp_pix.screen_y) begin
               $error("screen_y exp %h got %h", exp_pix.screen_y, rsp_screen_y); errors++;
            end
            if (rsp_ndc_x !== exp_pix.ndc_x) begin
               $error("ndc_x exp %h got %h", exp_pix.ndc_x, rsp_ndc_x); errors++;
            end
            if (rsp_ndc_y !== exp_pix.ndc_y) begin
               $error("ndc_y exp %h got %h", exp_pix.ndc_y, rsp_ndc_y); errors++;
            end
            if (rsp_recip_z !== exp_pix.recip_z) begin
               $error("recip_z exp %h got %h", exp_pix.recip_z, rsp_recip_z); errors++;
            end
            if (rsp_tex_u_out !== exp_pix.tex_u) begin
               $error("tex_u_out exp %h got %h", exp_pix.tex_u, rsp_tex_u_out); errors++;
            end
            if (rsp_tex_v_out !== exp_pix.tex_v) begin
               $error("tex_v_out exp %h got %h", exp_pix.tex_v, rsp_tex_v_out); errors++;
            end
            if (rsp_range_error !== exp_pix.range_error) begin
               $error("range_error exp %b got %b", exp_pix.range_error, rsp_range_error);
               errors++;
            end
            if (rsp_last_out !== exp_pix.last) begin
               $error("last_out exp %b got %b", exp_pix.last, rsp_last_out); errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end
endmodule
